>>> rtl/rcsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsg_pkg
// Shared constants, register indexes and the quarter-wave cosine table.
// ----------------------------------------------------------------------------
package rcsg_pkg;

   localparam int FRAME_BITS = 12;
   localparam int COS_LOG2   = 8;
   localparam int COS_DEPTH  = 1 << COS_LOG2;
   localparam int TURN_LOG2  = COS_LOG2 + 2;
   localparam int DIV_BITS   = FRAME_BITS + TURN_LOG2;
   localparam int Z_BITS     = 16;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_ADDR_BITS-1:0] REG_LIFT     = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_DUTY     = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_FRAMES   = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_STANCE   = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] REG_INTERVAL = 3'd4;

   localparam logic ACT_START = 1'b0;
   localparam logic ACT_TICK  = 1'b1;

   localparam logic [15:0]           LIFT_RESET     = 16'd5120;
   localparam logic [15:0]           DUTY_RESET     = 16'd32768;
   localparam logic [FRAME_BITS-1:0] FRAMES_RESET   = 12'd100;
   localparam logic [15:0]           STANCE_RESET   = 16'd0;
   localparam logic [15:0]           INTERVAL_RESET = 16'd10;

   typedef logic [16:0] cos_rom_type [0:COS_DEPTH];

   // Q30 Taylor series through x^10, rounded to Q16
   function automatic cos_rom_type build_cos_rom();
      cos_rom_type     rom;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned p;
      longint unsigned one;
      one = 64'd1 << 30;
      for (int i = 0; i <= COS_DEPTH; i++) begin
         x  = (longint'(i) * 64'd1686629713) / COS_DEPTH;
         x2 = (x * x) >> 30;
         t  = one;
         p  = ((x2 * t) >> 30) / 90;
         t  = (p >= one) ? 64'd0 : one - p;
         p  = ((x2 * t) >> 30) / 56;
         t  = (p >= one) ? 64'd0 : one - p;
         p  = ((x2 * t) >> 30) / 30;
         t  = (p >= one) ? 64'd0 : one - p;
         p  = ((x2 * t) >> 30) / 12;
         t  = (p >= one) ? 64'd0 : one - p;
         p  = ((x2 * t) >> 30) / 2;
         t  = (p >= one) ? 64'd0 : one - p;
         rom[i] = 17'((t + 64'd8192) >> 14);
      end
      return rom;
   endfunction

   localparam cos_rom_type COS_ROM = build_cos_rom();

endpackage

>>> rtl/rcsg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsg_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rcsg_div import rcsg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIV_BITS-1:0]   dividend,
   input  logic [FRAME_BITS-1:0] divisor,
   output logic                  done,
   output logic [TURN_LOG2-1:0]  quotient
);

   localparam int CNT_BITS = $clog2(DIV_BITS);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [DIV_BITS-1:0]   num_ff, num_in;
   logic [FRAME_BITS-1:0] rem_ff, rem_in;
   logic [FRAME_BITS-1:0] dvs_ff, dvs_in;
   logic [FRAME_BITS:0]   rem_sh;
   logic                  ge;

   assign rem_sh = {rem_ff, num_ff[DIV_BITS-1]};
   assign ge     = rem_sh >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(DIV_BITS - 1);
         num_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? FRAME_BITS'(rem_sh - {1'b0, dvs_ff}) : rem_sh[FRAME_BITS-1:0];
         num_in = {num_ff[DIV_BITS-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff[TURN_LOG2-1:0];

endmodule

>>> rtl/raised_cosine_step_gait_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raised_cosine_step_gait_generator
// Trot-in-place leg height generator: paces frames from tick items and
// emits raised cosine swing heights for the two diagonal leg pairs.
// Sequence: a frame-emitting tick runs the 22-step serial divider for the
//   cosine angle, then the table, multiply and sum stages; a start item
//   passes through ST_START to set the swing count.
// Flow: a new item is taken only once the block is back in idle; a result
//   may wait on the output register while the next item is taken.
// Reset: synchronous, clears the run state and restores register defaults.
// ----------------------------------------------------------------------------
module raised_cosine_step_gait_generator import rcsg_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [15:0]              req_tdata,   // repeat_count
   input  logic [0:0]               req_tuser,   // action
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [79:0]              rsp_tdata,   // right_front_z, left_front_z,
                                                 // right_back_z, left_back_z,
                                                 // frame_number, zero pad
   output logic [0:0]               rsp_tuser,   // phase
   output logic                     rsp_tlast,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_START = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_COS   = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_FIN   = 3'd5;

   localparam logic [FRAME_BITS-1:0] FMASK = '1;

   // configuration
   logic [15:0]           lift_ff, duty_ff, stance_ff, intv_ff;
   logic [FRAME_BITS-1:0] fpc_ff;

   // run state
   logic [2:0]            st_ff, st_in;
   logic                  running_ff, running_in;
   logic                  first_ff, first_in;
   logic [FRAME_BITS-1:0] k_ff, k_in;
   logic [FRAME_BITS-1:0] swing_ff, swing_in;
   logic [15:0]           cyc_ff, cyc_in;
   logic [15:0]           tsf_ff, tsf_in;

   // frame work registers
   logic [FRAME_BITS-1:0] j_ff, j_in;
   logic [FRAME_BITS-1:0] fnum_ff, fnum_in;
   logic                  ph_ff, ph_in;
   logic                  fin_ff, fin_in;
   logic [16:0]           h_ff, h_in;
   logic [32:0]           prod_ff, prod_in;

   // output register
   logic                  ovalid_ff, ovalid_in;
   logic [79:0]           odata_ff, odata_in;
   logic                  ophase_ff, ophase_in;
   logic                  olast_ff, olast_in;

   logic                  acc;
   logic                  tick_emit;
   logic                  ph_now, end_now, fin_now;
   logic [FRAME_BITS:0]   k_plus;
   logic                  div_start, div_done;
   logic [TURN_LOG2-1:0]  div_quo;
   logic [15:0]           mul_a;
   logic [16:0]           mul_b;
   logic [32:0]           mul_p;
   logic [FRAME_BITS-1:0] swing_raw;
   logic [TURN_LOG2-COS_LOG2-1:0] quad;
   logic [COS_LOG2:0]     cos_idx;
   logic [16:0]           cos_val;
   logic [17:0]           cos_sum;
   logic [16:0]           dz;
   logic [17:0]           base18, sw18;
   logic [Z_BITS-1:0]     base_z, sw_z;

   assign req_tready = (st_ff == ST_IDLE);
   assign acc        = req_tvalid && req_tready;

   assign tick_emit = running_ff && (first_ff || tsf_ff >= intv_ff);
   assign ph_now    = k_ff >= swing_ff;
   assign k_plus    = {1'b0, k_ff} + 1'b1;
   assign end_now   = ph_now && (k_plus >= {1'b0, fpc_ff} || k_ff == FMASK);
   assign fin_now   = end_now && cyc_ff <= 16'd1;

   rcsg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({j_in, {TURN_LOG2{1'b0}}}),
      .divisor  (swing_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // shared multiplier: swing count at start, lift scaling per frame
   assign mul_a     = (st_ff == ST_START) ? duty_ff : lift_ff;
   assign mul_b     = (st_ff == ST_START) ? {5'd0, fpc_ff} : h_ff;
   assign mul_p     = mul_a * mul_b;
   assign swing_raw = mul_p[16 +: FRAME_BITS];

   // quarter-wave lookup
   assign quad    = div_quo[TURN_LOG2-1:COS_LOG2];
   assign cos_idx = quad[0] ? (COS_LOG2+1)'(COS_DEPTH) - {1'b0, div_quo[COS_LOG2-1:0]}
                            : {1'b0, div_quo[COS_LOG2-1:0]};
   assign cos_val = COS_ROM[cos_idx];
   assign cos_sum = (quad[0] ^ quad[1]) ? 18'd65536 + {1'b0, cos_val}
                                        : 18'd65536 - {1'b0, cos_val};

   // final sum with saturation
   assign dz     = 17'((prod_ff + 33'd32768) >> 16);
   assign base18 = {{2{stance_ff[15]}}, stance_ff};
   assign sw18   = base18 - {1'b0, dz};
   assign base_z = stance_ff;
   assign sw_z   = ($signed(sw18) < -18'sd32768) ? 16'h8000 : sw18[15:0];

   always_comb begin
      st_in      = st_ff;
      running_in = running_ff;
      first_in   = first_ff;
      k_in       = k_ff;
      swing_in   = swing_ff;
      cyc_in     = cyc_ff;
      tsf_in     = tsf_ff;
      j_in       = j_ff;
      fnum_in    = fnum_ff;
      ph_in      = ph_ff;
      fin_in     = fin_ff;
      h_in       = h_ff;
      prod_in    = prod_ff;
      ovalid_in  = ovalid_ff && !rsp_tready;
      odata_in   = odata_ff;
      ophase_in  = ophase_ff;
      olast_in   = olast_ff;
      div_start  = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (acc) begin
               if (req_tuser[0] == ACT_START) begin
                  st_in      = ST_START;
                  cyc_in     = req_tdata;
                  running_in = (req_tdata != 16'd0);
                  k_in       = '0;
                  tsf_in     = '0;
                  first_in   = 1'b1;
               end else if (running_ff) begin
                  if (tick_emit) begin
                     first_in  = 1'b0;
                     tsf_in    = '0;
                     j_in      = ph_now ? k_ff - swing_ff : k_ff;
                     fnum_in   = k_ff;
                     ph_in     = ph_now;
                     fin_in    = fin_now;
                     div_start = 1'b1;
                     st_in     = ST_DIV;
                     if (end_now) begin
                        k_in   = '0;
                        cyc_in = fin_now ? 16'd0 : cyc_ff - 16'd1;
                        if (fin_now) begin
                           running_in = 1'b0;
                        end else begin
                           first_in = 1'b1;
                        end
                     end else begin
                        k_in = k_plus[FRAME_BITS-1:0];
                     end
                  end else begin
                     tsf_in = tsf_ff + 16'd1;
                  end
               end
            end
         end
         ST_START: begin
            swing_in = (swing_raw == '0) ? FRAME_BITS'(1) : swing_raw;
            st_in    = ST_IDLE;
         end
         ST_DIV: begin
            if (div_done) begin
               st_in = ST_COS;
            end
         end
         ST_COS: begin
            h_in  = cos_sum[17:1];
            st_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in = mul_p;
            st_in   = ST_FIN;
         end
         ST_FIN: begin
            if (!ovalid_ff || rsp_tready) begin
               ovalid_in = 1'b1;
               odata_in  = {4'd0, fnum_ff,
                            ph_ff ? base_z : sw_z,
                            ph_ff ? sw_z   : base_z,
                            ph_ff ? sw_z   : base_z,
                            ph_ff ? base_z : sw_z};
               ophase_in = ph_ff;
               olast_in  = fin_ff;
               st_in     = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lift_ff    <= LIFT_RESET;
         duty_ff    <= DUTY_RESET;
         fpc_ff     <= FRAMES_RESET;
         stance_ff  <= STANCE_RESET;
         intv_ff    <= INTERVAL_RESET;
         st_ff      <= ST_IDLE;
         running_ff <= 1'b0;
         first_ff   <= 1'b0;
         k_ff       <= '0;
         swing_ff   <= '0;
         cyc_ff     <= '0;
         tsf_ff     <= '0;
         ovalid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_LIFT:     lift_ff   <= csr_wdata;
               REG_DUTY:     duty_ff   <= csr_wdata;
               REG_FRAMES:   fpc_ff    <= csr_wdata[FRAME_BITS-1:0];
               REG_STANCE:   stance_ff <= csr_wdata;
               REG_INTERVAL: intv_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
         st_ff      <= st_in;
         running_ff <= running_in;
         first_ff   <= first_in;
         k_ff       <= k_in;
         swing_ff   <= swing_in;
         cyc_ff     <= cyc_in;
         tsf_ff     <= tsf_in;
         ovalid_ff  <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff      <= j_in;
      fnum_ff   <= fnum_in;
      ph_ff     <= ph_in;
      fin_ff    <= fin_in;
      h_ff      <= h_in;
      prod_ff   <= prod_in;
      odata_ff  <= odata_in;
      ophase_ff <= ophase_in;
      olast_ff  <= olast_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tuser  = ophase_ff;
   assign rsp_tlast  = olast_ff;

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for raised_cosine_step_gait_generator. Start and tick items
// go in on the req stream with random gaps. A tracker class keeps its own
// copy of the gait state and the registers, works out each leg height
// frame when an item is accepted, and checks every frame on the rsp
// stream in order. The runs cover directed corner cases and then random
// register settings with random start/tick sequences. Both sides stall
// at random, and the rsp side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb import rcsg_pkg::*; ;

   localparam int QUARTER   = 256;
   localparam int TURN      = 4 * QUARTER;
   localparam int FRAME_MAX = 4095;
   localparam int SETTLE    = 40;

   typedef struct {
      logic signed [15:0] rf;
      logic signed [15:0] lf;
      logic signed [15:0] rb;
      logic signed [15:0] lb;
      logic [11:0]        frame;
      bit                 phase;
      bit                 last;
   } leg_frame_type;

   class leg_height_tracker;
      logic [15:0]        lift;
      logic [15:0]        duty;
      logic [11:0]        frames;
      logic signed [15:0] stance;
      logic [15:0]        interval;
      bit                 running;
      int                 frame_idx;
      logic [15:0]        cycles_left;
      logic [15:0]        tick_count;
      bit                 first_pending;
      int                 swing;
      int                 cos_q16 [0:QUARTER];
      leg_frame_type      frames_due [$];
      int                 errors;

      function new();
         longint unsigned x;
         longint unsigned x2;
         longint unsigned t;
         longint unsigned p;
         longint unsigned one;
         int unsigned     divs [5] = '{90, 56, 30, 12, 2};
         one = 64'd1 << 30;
         for (int i = 0; i <= QUARTER; i++) begin
            x  = (longint'(i) * 64'd1686629713) / QUARTER;
            x2 = (x * x) >> 30;
            t  = one;
            foreach (divs[d]) begin
               p = ((x2 * t) >> 30) / divs[d];
               t = (p >= one) ? 64'd0 : one - p;
            end
            cos_q16[i] = int'((t + 64'd8192) >> 14);
         end
         lift     = LIFT_RESET;
         duty     = DUTY_RESET;
         frames   = FRAMES_RESET;
         stance   = STANCE_RESET;
         interval = INTERVAL_RESET;
         running       = 1'b0;
         frame_idx     = 0;
         cycles_left   = '0;
         tick_count    = '0;
         first_pending = 1'b0;
         swing         = 0;
         errors        = 0;
      endfunction

      function void set_reg(logic [CSR_ADDR_BITS-1:0] idx, logic [15:0] v);
         case (idx)
            REG_LIFT:     lift     = v;
            REG_DUTY:     duty     = v;
            REG_FRAMES:   frames   = v[11:0];
            REG_STANCE:   stance   = v;
            REG_INTERVAL: interval = v;
            default: ;
         endcase
      endfunction

      function void next_frame();
         int            k;
         int            s;
         int            j;
         int            a;
         int            c;
         int            h;
         longint        dz;
         int            base;
         int            sw;
         bit            ph;
         bit            ends;
         bit            fin;
         leg_frame_type f;
         k  = frame_idx;
         s  = swing;
         ph = (k >= s);
         j  = ph ? k - s : k;
         a  = int'((longint'(j) * TURN) / s % TURN);
         case (a / QUARTER)
            0:       c = cos_q16[a % QUARTER];
            1:       c = -cos_q16[QUARTER - a % QUARTER];
            2:       c = -cos_q16[a % QUARTER];
            default: c = cos_q16[QUARTER - a % QUARTER];
         endcase
         h    = (65536 - c) >> 1;
         dz   = (longint'(lift) * h + 32768) >> 16;
         base = stance;
         sw   = base - int'(dz);
         if (sw < -32768) sw = -32768;
         f.rf    = ph ? base : sw;
         f.lf    = ph ? sw : base;
         f.rb    = ph ? sw : base;
         f.lb    = ph ? base : sw;
         f.frame = k;
         f.phase = ph;
         ends = ph && (k + 1 >= int'(frames) || k >= FRAME_MAX);
         fin  = 1'b0;
         if (ends) begin
            fin = (cycles_left <= 16'd1);
            cycles_left = fin ? 16'd0 : cycles_left - 16'd1;
            frame_idx = 0;
            if (fin) running = 1'b0;
            else first_pending = 1'b1;
         end else begin
            frame_idx = (k + 1) % (FRAME_MAX + 1);
         end
         f.last = fin;
         tick_count = '0;
         frames_due.push_back(f);
      endfunction

      // returns 0 for an item that the block drops (tick while idle)
      function bit take_item(logic act, logic [15:0] rep);
         int s;
         if (act == ACT_START) begin
            s = (int'(duty) * int'(frames)) >> 16;
            if (s < 1) s = 1;
            if (s > FRAME_MAX) s = FRAME_MAX;
            swing         = s;
            cycles_left   = rep;
            running       = (rep != 16'd0);
            frame_idx     = 0;
            tick_count    = '0;
            first_pending = 1'b1;
            return 1'b1;
         end
         if (!running) return 1'b0;
         if (first_pending) begin
            first_pending = 1'b0;
            next_frame();
         end else if (tick_count >= interval) begin
            next_frame();
         end else begin
            tick_count = tick_count + 16'd1;
         end
         return 1'b1;
      endfunction

      function void check_field(string name, int want, int got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void match_frame(logic [79:0] data, logic ph, logic lst);
         leg_frame_type e;
         if (frames_due.size() == 0) begin
            $error("frame with none expected: frame_number %0d", data[75:64]);
            errors++;
            return;
         end
         e = frames_due.pop_front();
         check_field("right_front_z", e.rf, $signed(data[15:0]));
         check_field("left_front_z", e.lf, $signed(data[31:16]));
         check_field("right_back_z", e.rb, $signed(data[47:32]));
         check_field("left_back_z", e.lb, $signed(data[63:48]));
         check_field("frame_number", e.frame, data[75:64]);
         check_field("phase", e.phase, ph);
         check_field("last", e.last, lst);
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [15:0]              req_tdata;   // repeat_count
   logic [0:0]               req_tuser;   // action
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [79:0]              rsp_tdata;   // right_front_z, left_front_z, right_back_z,
                                          // left_back_z, frame_number, zero pad
   logic [0:0]               rsp_tuser;   // phase
   logic                     rsp_tlast;
   logic                     csr_we;
   logic [CSR_ADDR_BITS-1:0] csr_addr;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   leg_height_tracker sb;
   logic [15:0]       cfg_val [5];
   bit                no_idle;
   bit                hold_request;
   int                live_items;

   raised_cosine_step_gait_generator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(12, 60);
   endfunction

   function automatic logic [15:0] pick_count();
      case ($urandom_range(0, 9))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return 16'($urandom);
         default: return 16'($urandom_range(1, 3));
      endcase
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_item(input logic act, input logic [15:0] rep);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= rep;
      do @(posedge clock); while (!req_tready);
      void'(sb.take_item(act, rep));
      live_items++;
      @(negedge clock);
   endtask

   task automatic load_regs(input bit [4:0] sel);
      for (int i = REG_LIFT; i <= REG_INTERVAL; i++) begin
         if (sel[i]) begin
            csr_we    <= 1'b1;
            csr_addr  <= CSR_ADDR_BITS'(i);
            csr_wdata <= cfg_val[i];
            @(negedge clock);
            sb.set_reg(CSR_ADDR_BITS'(i), cfg_val[i]);
         end
      end
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      while (sb.frames_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.match_frame(rsp_tdata, rsp_tuser[0], rsp_tlast);
   end

   initial begin
      int hold_left;
      int stall_left;
      hold_left  = 0;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   initial begin
      #10_000_000;
      $display("tb: errors");
      $finish;
   end

   initial begin
      int          phase_no;
      int          n;
      bit [4:0]    sel;
      phase_no     = 0;
      no_idle      = 1'b0;
      hold_request = 1'b0;
      live_items   = 0;
      sb           = new();
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = ACT_TICK;
      csr_we       = 1'b0;
      csr_addr     = REG_LIFT;
      csr_wdata    = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // tick while idle, empty run, tick after an empty run
      send_item(ACT_TICK, 16'hFFFF);
      send_item(ACT_START, 16'd0);
      send_item(ACT_TICK, 16'h0000);
      req_tvalid <= 1'b0;
      wait_idle();

      // one frame per phase, stance at the bottom, full lift
      cfg_val[REG_LIFT]     = 16'hFFFF;
      cfg_val[REG_DUTY]     = 16'h0000;
      cfg_val[REG_FRAMES]   = 16'd1;
      cfg_val[REG_STANCE]   = 16'h8000;
      cfg_val[REG_INTERVAL] = 16'd0;
      load_regs(5'h1F);
      send_item(ACT_START, 16'd2);
      repeat (4) send_item(ACT_TICK, 16'h5555);
      req_tvalid <= 1'b0;
      wait_idle();

      // zero frame count, full duty, restart while running
      cfg_val[REG_LIFT]     = 16'h0A00;
      cfg_val[REG_DUTY]     = 16'hFFFF;
      cfg_val[REG_FRAMES]   = 16'd0;
      cfg_val[REG_STANCE]   = 16'h7FFF;
      cfg_val[REG_INTERVAL] = 16'd1;
      load_regs(5'h1F);
      send_item(ACT_START, 16'hFFFF);
      repeat (3) send_item(ACT_TICK, 16'hAAAA);
      send_item(ACT_START, 16'd1);
      repeat (2) send_item(ACT_TICK, 16'h00FF);
      req_tvalid <= 1'b0;
      wait_idle();

      // short swing, phase 1 angle wraps past a full turn
      cfg_val[REG_LIFT]     = 16'd5120;
      cfg_val[REG_DUTY]     = 16'd19661;
      cfg_val[REG_FRAMES]   = 16'd10;
      cfg_val[REG_STANCE]   = 16'd0;
      cfg_val[REG_INTERVAL] = 16'd0;
      load_regs(5'h1F);
      send_item(ACT_START, 16'd1);
      repeat (10) send_item(ACT_TICK, 16'hFF00);
      req_tvalid <= 1'b0;
      wait_idle();

      while (live_items < 700) begin
         case ($urandom_range(0, 7))
            0:       cfg_val[REG_LIFT] = 16'd0;
            1:       cfg_val[REG_LIFT] = 16'hFFFF;
            default: cfg_val[REG_LIFT] = 16'($urandom_range(0, 12800));
         endcase
         case ($urandom_range(0, 7))
            0:       cfg_val[REG_DUTY] = 16'd0;
            1:       cfg_val[REG_DUTY] = 16'hFFFF;
            default: cfg_val[REG_DUTY] = 16'($urandom);
         endcase
         case ($urandom_range(0, 9))
            0:       cfg_val[REG_FRAMES] = 16'd0;
            1:       cfg_val[REG_FRAMES] = 16'd4095;
            2:       cfg_val[REG_FRAMES] = 16'd1;
            default: cfg_val[REG_FRAMES] = 16'($urandom_range(2, 24));
         endcase
         case ($urandom_range(0, 7))
            0:       cfg_val[REG_STANCE] = 16'h8000;
            1:       cfg_val[REG_STANCE] = 16'h7FFF;
            default: cfg_val[REG_STANCE] = 16'($urandom);
         endcase
         case ($urandom_range(0, 9))
            0:          cfg_val[REG_INTERVAL] = 16'hFFFF;
            1, 2, 3, 4: cfg_val[REG_INTERVAL] = 16'd0;
            default:    cfg_val[REG_INTERVAL] = 16'($urandom_range(1, 4));
         endcase
         sel = 5'($urandom);
         // steady frame stream so the long rsp hold backs up into req
         if (phase_no == 2) begin
            cfg_val[REG_FRAMES]   = 16'd12;
            cfg_val[REG_INTERVAL] = 16'd0;
            sel = 5'h1F;
         end
         load_regs(sel);
         no_idle = ($urandom_range(0, 3) == 0) || (phase_no == 2);
         n = $urandom_range(20, 60);
         if (phase_no == 2) begin
            send_item(ACT_START, 16'd3);
            hold_request = 1'b1;
         end else if ($urandom_range(0, 9) != 0) begin
            send_item(ACT_START, pick_count());
         end
         repeat (n) begin
            if ($urandom_range(0, 24) == 0) send_item(ACT_START, pick_count());
            else send_item(ACT_TICK, 16'($urandom));
         end
         req_tvalid <= 1'b0;
         wait_idle();
         phase_no++;
      end

      if (sb.errors == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end

endmodule
